@@ src/layer_z_order_stack_macros.svh @@
// Assertion macros shared by the stacking block.
`ifndef LAYER_Z_ORDER_STACK_MACROS_SVH
`define LAYER_Z_ORDER_STACK_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define LZS_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous reset.
`define LZS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lzs_pkg.sv @@
// Shared constants, action codes and cell command type for the layer stack.
`timescale 1ns / 1ps
`default_nettype none
package lzs_pkg;

  localparam int MAX_LAYERS = 32;
  localparam int IDX_W      = $clog2(MAX_LAYERS);
  localparam int DEP_W      = IDX_W + 1;
  localparam int CW         = (IDX_W + 3 > 8) ? IDX_W + 3 : 8;
  localparam int CNT_W      = $clog2(MAX_LAYERS + 1);
  localparam int SLOT_W     = 5;
  localparam int ADDR_N     = (MAX_LAYERS < 32) ? MAX_LAYERS : 32;

  typedef enum logic [2:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE  = 3'd1,
    ACT_SET   = 3'd2,
    ACT_FIND  = 3'd3,
    ACT_ABOVE = 3'd4,
    ACT_BELOW = 3'd5,
    ACT_TOP   = 3'd6,
    ACT_NONE  = 3'd7
  } lzs_act_t;

  typedef struct packed {
    logic                    shift_en;
    logic                    from_below;
    logic signed [CW-1:0]    slo;
    logic signed [CW-1:0]    shi;
    logic                    ins;
    logic signed [CW-1:0]    ins_pos;
    logic [SLOT_W-1:0]       ins_layer;
    logic                    adj_en;
    logic                    adj_up;
    logic signed [CW-1:0]    llo;
    logic signed [CW-1:0]    lhi;
    logic [IDX_W-1:0]        tgt;
    logic                    dep_wr;
    logic signed [DEP_W-1:0] tgt_depth;
    logic                    use_set;
    logic                    use_clr;
  } lzs_cmd_t;

endpackage
`default_nettype wire

@@ src/lzs_slot_cell.sv @@
// One depth position of the stack: holds the layer at that depth and shifts with neighbors.
`timescale 1ns / 1ps
`default_nettype none
module lzs_slot_cell (
  input  wire                           clk,
  input  wire [lzs_pkg::IDX_W-1:0]      idx,
  input  wire                           en,
  input  lzs_pkg::lzs_cmd_t             cmd,
  input  wire [lzs_pkg::SLOT_W-1:0]     prev,
  input  wire [lzs_pkg::SLOT_W-1:0]     next,
  output logic [lzs_pkg::SLOT_W-1:0]    slot
);
  import lzs_pkg::*;

  logic signed [CW-1:0] pos;

  assign pos = CW'($signed({1'b0, idx}));

  always_ff @(posedge clk) begin
    if (en) begin
      if (cmd.ins && pos == cmd.ins_pos) begin
        slot <= cmd.ins_layer;
      end else if (cmd.shift_en && pos >= cmd.slo && pos <= cmd.shi) begin
        slot <= cmd.from_below ? prev : next;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/lzs_layer_cell.sv @@
// One layer of the pool: holds its depth and allocation flag.
`timescale 1ns / 1ps
`default_nettype none
module lzs_layer_cell (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire [lzs_pkg::IDX_W-1:0]             idx,
  input  wire                                  en,
  input  lzs_pkg::lzs_cmd_t                    cmd,
  output logic signed [lzs_pkg::DEP_W-1:0]     depth,
  output logic                                 in_use
);
  import lzs_pkg::*;

  logic signed [CW-1:0] dw;
  logic                 hit;
  logic                 in_rng;

  assign dw     = CW'(depth);
  assign hit    = (idx == cmd.tgt);
  assign in_rng = cmd.adj_en && dw >= cmd.llo && dw <= cmd.lhi;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= -DEP_W'(1);
      in_use <= 1'b0;
    end else if (en) begin
      if (hit && (cmd.dep_wr || cmd.use_set || cmd.use_clr)) begin
        if (cmd.dep_wr) begin
          depth <= cmd.tgt_depth;
        end
        if (cmd.use_set) begin
          in_use <= 1'b1;
        end
        if (cmd.use_clr) begin
          in_use <= 1'b0;
        end
      end else if (in_rng) begin
        depth <= cmd.adj_up ? depth + DEP_W'(1) : depth - DEP_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/layer_z_order_stack.sv @@
// Layer stacking order: decode and clamp, then apply the move across the cell rows.
// Decode registers an accepted transaction; EXEC applies it to the cells and the output register.
// A new transaction is taken only in IDLE, once the previous one has been applied.
// A stalled result holds; the next transaction is taken meanwhile and waits in apply.
// Reset: all layers free and hidden, visible count zero; stack contents stay undefined
// until written, so there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "layer_z_order_stack_macros.svh"
module layer_z_order_stack (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire [2:0]         action,
  input  wire [4:0]         layer,
  input  wire signed [6:0]  depth,
  input  wire signed [5:0]  offset,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [4:0]        result_layer,
  output logic              found,
  output logic signed [5:0] new_depth,
  output logic [5:0]        visible_count,
  output logic              redraw,
  output logic [5:0]        map_from_depth,
  output logic [4:0]        draw_low,
  output logic signed [5:0] draw_high
);
  import lzs_pkg::*;

  typedef enum logic {IDLE, EXEC} state_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    res;
    logic                 found;
    logic signed [CW-1:0] nd;
    logic                 redraw;
    logic signed [CW-1:0] map_from;
    logic signed [CW-1:0] low;
    logic signed [CW-1:0] high;
    logic [CNT_W-1:0]     cnt;
  } res_t;

  state_t            state;
  lzs_cmd_t          cmd;
  lzs_cmd_t          cmd_next;
  res_t              rsl;
  res_t              rsl_next;
  logic [CNT_W-1:0]  count;
  logic              apply;

  logic [SLOT_W-1:0]       slot_q  [MAX_LAYERS];
  logic signed [DEP_W-1:0] depth_q [MAX_LAYERS];
  logic                    use_q   [MAX_LAYERS];

  logic                 lay_ok;
  logic [IDX_W-1:0]     lay_idx;
  logic                 lay_use;
  logic signed [CW-1:0] top;
  logic signed [CW-1:0] old;
  logic signed [CW-1:0] req;
  logic signed [CW-1:0] z;
  logic signed [CW-1:0] zf;
  logic                 find_ok;
  logic                 free_ok;
  logic [IDX_W-1:0]     free_idx;
  logic                 move;
  logic                 show;
  logic                 hide;

  assign in_stall = (state != IDLE);
  assign apply    = (state == EXEC) && (!out_valid || !out_stall);

  genvar h;
  for (h = 0; h < MAX_LAYERS; h++) begin : g_cell
    logic [SLOT_W-1:0] prev_v;
    logic [SLOT_W-1:0] next_v;
    if (h == 0) begin : g_lo
      assign prev_v = '0;
    end else begin : g_lo
      assign prev_v = slot_q[h-1];
    end
    if (h == MAX_LAYERS - 1) begin : g_hi
      assign next_v = '0;
    end else begin : g_hi
      assign next_v = slot_q[h+1];
    end
    lzs_slot_cell u_slot (
      .clk  (clk),
      .idx  (IDX_W'(h)),
      .en   (apply),
      .cmd  (cmd),
      .prev (prev_v),
      .next (next_v),
      .slot (slot_q[h])
    );
    lzs_layer_cell u_layer (
      .clk    (clk),
      .rst    (rst),
      .idx    (IDX_W'(h)),
      .en     (apply),
      .cmd    (cmd),
      .depth  (depth_q[h]),
      .in_use (use_q[h])
    );
  end

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = ADDR_N - 1; i >= 0; i--) begin
      if (!use_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cmd_next = '0;
    move     = 1'b0;
    show     = 1'b0;
    hide     = 1'b0;
    lay_ok   = int'(layer) < MAX_LAYERS;
    lay_idx  = IDX_W'(layer);
    lay_use  = lay_ok && use_q[lay_idx];
    top      = CW'($signed({1'b0, count})) - CW'(1);
    old      = lay_ok ? CW'(depth_q[lay_idx]) : -CW'(1);

    unique case (action) inside
      ACT_SET:   req = CW'(depth);
      ACT_ABOVE: req = top + CW'(1);
      ACT_BELOW: req = top - CW'(1);
      ACT_TOP:   req = top;
      default:   req = -CW'(1);
    endcase

    if (old >= 0) begin
      z = (req > top) ? top : req;
    end else begin
      z = (req > top + CW'(1)) ? top + CW'(1) : req;
      if (z > CW'(MAX_LAYERS - 1)) begin
        z = CW'(MAX_LAYERS - 1);
      end
    end
    if (z < -CW'(1)) begin
      z = -CW'(1);
    end

    zf      = (offset >= 0) ? CW'(offset) : top + CW'(offset) + CW'(1);
    find_ok = (zf >= 0) && (zf <= top);

    rsl_next          = '0;
    rsl_next.res      = layer;
    rsl_next.nd       = old;
    rsl_next.high     = -CW'(1);

    unique case (action) inside
      ACT_ALLOC: begin
        if (free_ok) begin
          rsl_next.res     = SLOT_W'(free_idx);
          rsl_next.found   = 1'b1;
          rsl_next.nd      = -CW'(1);
          cmd_next.tgt     = free_idx;
          cmd_next.use_set = 1'b1;
        end
      end
      ACT_FIND: begin
        if (find_ok) begin
          rsl_next.res   = slot_q[IDX_W'(zf)];
          rsl_next.found = 1'b1;
          rsl_next.nd    = zf;
        end
      end
      ACT_FREE: begin
        if (lay_use) begin
          cmd_next.tgt     = lay_idx;
          cmd_next.use_clr = 1'b1;
          move             = (old >= 0);
        end
      end
      ACT_SET, ACT_ABOVE, ACT_BELOW, ACT_TOP: begin
        move = lay_use;
      end
      default: ;
    endcase

    if (move) begin
      rsl_next.nd = z;
      if (old != z) begin
        rsl_next.redraw    = 1'b1;
        cmd_next.tgt       = lay_idx;
        cmd_next.dep_wr    = 1'b1;
        cmd_next.tgt_depth = DEP_W'(z);
        cmd_next.shift_en  = 1'b1;
        cmd_next.adj_en    = 1'b1;
        cmd_next.ins_layer = layer;
        cmd_next.ins_pos   = z;
        if (old > z) begin
          if (z >= 0) begin
            cmd_next.from_below = 1'b1;
            cmd_next.slo        = z + CW'(1);
            cmd_next.shi        = old;
            cmd_next.ins        = 1'b1;
            cmd_next.adj_up     = 1'b1;
            cmd_next.llo        = z;
            cmd_next.lhi        = old - CW'(1);
            rsl_next.map_from   = z + CW'(1);
            rsl_next.low        = z + CW'(1);
            rsl_next.high       = old;
          end else begin
            hide                = 1'b1;
            cmd_next.slo        = old;
            cmd_next.shi        = top - CW'(1);
            cmd_next.llo        = old + CW'(1);
            cmd_next.lhi        = top;
            rsl_next.high       = old - CW'(1);
          end
        end else begin
          cmd_next.ins      = 1'b1;
          rsl_next.map_from = z;
          rsl_next.low      = z;
          rsl_next.high     = z;
          if (old >= 0) begin
            cmd_next.slo = old;
            cmd_next.shi = z - CW'(1);
            cmd_next.llo = old + CW'(1);
            cmd_next.lhi = z;
          end else begin
            show                = 1'b1;
            cmd_next.from_below = 1'b1;
            cmd_next.slo        = z + CW'(1);
            cmd_next.shi        = top + CW'(1);
            cmd_next.adj_up     = 1'b1;
            cmd_next.llo        = z;
            cmd_next.lhi        = top;
          end
        end
      end
    end

    rsl_next.cnt = count + CNT_W'(show) - CNT_W'(hide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (out_valid && !out_stall && !apply) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= EXEC;
            cmd   <= cmd_next;
            rsl   <= rsl_next;
          end
        end
        EXEC: begin
          if (apply) begin
            state          <= IDLE;
            out_valid      <= 1'b1;
            count          <= rsl.cnt;
            result_layer   <= rsl.res;
            found          <= rsl.found;
            new_depth      <= 6'(rsl.nd);
            visible_count  <= 6'(rsl.cnt);
            redraw         <= rsl.redraw;
            map_from_depth <= 6'(rsl.map_from);
            draw_low       <= 5'(rsl.low);
            draw_high      <= 6'(rsl.high);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `LZS_ASSERT_NEXT(a_accept_holds_off, clk, rst, in_valid && !in_stall, in_stall, "second transaction taken while one is in flight")
  `LZS_ASSERT_NEXT(a_apply_shows_result, clk, rst, apply, out_valid && !in_stall, "applied transaction left no result")
  `LZS_ASSERT_NEXT(a_count_only_on_apply, clk, rst, !apply, $stable(count), "visible count changed outside apply")
  `LZS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_LAYERS), "visible count beyond the pool")

endmodule
`default_nettype wire
